@@ hw/rtl/tcr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcr_pkg
// shared types, codes and the arctangent table for the tilt-corrected ranger
// ----------------------------------------------------------------------------
package tcr_pkg;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FAULT     = 2'd1;
  localparam logic [1:0] ST_LOW_ACCEL = 2'd2;
  localparam logic [1:0] ST_NO_RANGE  = 2'd3;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic [15:0] TILT_MAX     = 16'd51472;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQUARE,
    OP_SQRT1_INIT,
    OP_SQRT_STEP,
    OP_CHECK,
    OP_DIV_STEP,
    OP_MUL,
    OP_SQRT2_INIT,
    OP_COR_INIT,
    OP_COR_STEP,
    OP_OUT
  } tcr_op_e;

  // controller to datapath
  typedef struct packed {
    tcr_op_e    op;
    logic [3:0] idx;
  } tcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;
  } tcr_sts_t;

  // arctangent of 2^-i in Q1.15 radians
  function automatic logic [15:0] tcr_atan(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd25736;
      4'd1:    v = 16'd15193;
      4'd2:    v = 16'd8027;
      4'd3:    v = 16'd4075;
      4'd4:    v = 16'd2045;
      4'd5:    v = 16'd1024;
      4'd6:    v = 16'd512;
      4'd7:    v = 16'd256;
      4'd8:    v = 16'd128;
      4'd9:    v = 16'd64;
      4'd10:   v = 16'd32;
      4'd11:   v = 16'd16;
      4'd12:   v = 16'd8;
      4'd13:   v = 16'd4;
      4'd14:   v = 16'd2;
      default: v = 16'd1;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/tilt_corrected_range.sv @@
// ----------------------------------------------------------------------------
// tilt_corrected_range
// holds the last good slant range and corrects it for tilt from acceleration
// ----------------------------------------------------------------------------
// One transaction in gives one result out. A transaction is taken only while
// the block is idle; a full valid-range transaction runs the bit-serial
// magnitude root, the 16-step divider, the 16-step root for the sine and 16
// cordic steps, all one after another under the sequencer. Faults skip
// straight to the result, and low acceleration or no-range cases stop after
// the magnitude root and the check. The output register lets the next
// transaction be taken while a result still waits.
module tilt_corrected_range import tcr_pkg::*; #(
  parameter int unsigned ACCEL_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          sample_ready_i,
  input  logic [15:0]                   range_mm_i,
  input  logic                          range_good_i,
  input  logic signed [ACCEL_WIDTH-1:0] accel_x_i,
  input  logic signed [ACCEL_WIDTH-1:0] accel_y_i,
  input  logic signed [ACCEL_WIDTH-1:0] accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   held_range_mm_o,
  output logic                          held_range_known_o,
  output logic [15:0]                   vertical_mm_o,
  output logic [15:0]                   tilt_angle_o,
  output logic                          ok_o,
  output logic [1:0]                    status_o
);

  localparam logic REG_MIN_MAG = 1'b0;

  logic [15:0] min_mag_q;
  tcr_cmd_t    cmd;
  tcr_sts_t    sts;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= 16'd512;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_MAG) begin
      min_mag_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == REG_MIN_MAG) ? {16'd0, min_mag_q} : 32'd0;

  tcr_ctrl #(
    .AW (ACCEL_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tcr_datapath #(
    .AW (ACCEL_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .min_mag_i          (min_mag_q),
    .sample_ready_i     (sample_ready_i),
    .range_mm_i         (range_mm_i),
    .range_good_i       (range_good_i),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .held_range_mm_o    (held_range_mm_o),
    .held_range_known_o (held_range_known_o),
    .vertical_mm_o      (vertical_mm_o),
    .tilt_angle_o       (tilt_angle_o),
    .ok_o               (ok_o),
    .status_o           (status_o)
  );

endmodule

@@ hw/rtl/tcr_datapath.sv @@
// ----------------------------------------------------------------------------
// tcr_datapath
// shared squarer, bit-serial square root, restoring divider and cordic unit
// ----------------------------------------------------------------------------
module tcr_datapath import tcr_pkg::*; #(
  parameter int unsigned AW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcr_cmd_t             cmd_i,
  output tcr_sts_t             sts_o,
  input  logic [15:0]          min_mag_i,
  input  logic                 sample_ready_i,
  input  logic [15:0]          range_mm_i,
  input  logic                 range_good_i,
  input  logic signed [AW-1:0] accel_x_i,
  input  logic signed [AW-1:0] accel_y_i,
  input  logic signed [AW-1:0] accel_z_i,
  output logic [15:0]          held_range_mm_o,
  output logic                 held_range_known_o,
  output logic [15:0]          vertical_mm_o,
  output logic [15:0]          tilt_angle_o,
  output logic                 ok_o,
  output logic [1:0]           status_o
);

  localparam int unsigned SW = 2 * AW + 2;
  localparam int unsigned RW = (SW > 32) ? SW : 32;
  localparam int unsigned MW = AW + 1;
  localparam int unsigned DW = MW + 1;
  localparam int unsigned CW = (MW > 16) ? MW : 16;
  localparam int unsigned XW = 26;
  localparam int unsigned ZW = 18;

  logic [AW-1:0] ax_q, ay_q, az_q;
  logic [SW-1:0] sum_q;
  logic [RW-1:0] rad_q, res_q, bit_q;
  logic [MW-1:0] m_q;
  logic [DW-1:0] rem_q;
  logic          nb_q;
  logic [15:0]   quo_q;
  logic [15:0]   vert_q;
  logic [30:0]   cc_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [1:0]    status_q;
  logic [15:0]   last_range_q;
  logic          last_valid_q;

  // absolute values, the most negative code maps to its magnitude
  function automatic logic [AW-1:0] abs_f(input logic [AW-1:0] a);
    return a[AW-1] ? (~a + AW'(1)) : a;
  endfunction

  // squarer input select
  logic [AW-1:0]   sq_sel;
  logic [2*AW-1:0] sq_prod;
  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    sq_sel = ax_q;
      2'd1:    sq_sel = ay_q;
      default: sq_sel = az_q;
    endcase
    sq_prod = sq_sel * sq_sel;
  end

  // one square root step
  logic [RW-1:0] sq_trial;
  logic          sq_take;
  assign sq_trial = res_q + bit_q;
  assign sq_take  = (rad_q >= sq_trial);

  // one divider step
  logic [DW-1:0] dv_t;
  logic          dv_take;
  assign dv_t    = {rem_q[DW-2:0], nb_q};
  assign dv_take = (dv_t >= DW'(m_q));

  // range times cosine, and cosine squared
  logic [31:0] vm_prod;
  logic [32:0] vm_round;
  logic [17:0] vm_shift;
  logic [33:0] cc_prod;
  assign vm_prod  = last_range_q * quo_q;
  assign vm_round = {1'b0, vm_prod} + 33'd16384;
  assign vm_shift = vm_round[32:15];
  assign cc_prod  = {17'd0, quo_q} * {17'd0, quo_q};

  // cordic shifts
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atn;
  assign xs  = x_q >>> cmd_i.idx;
  assign ys  = y_q >>> cmd_i.idx;
  assign atn = ZW'(tcr_atan(cmd_i.idx));

  // low acceleration test
  logic low_acc;
  assign low_acc = (m_q == '0) || (CW'(m_q) < CW'(min_mag_i));

  // tilt clip
  logic [15:0] tilt_clip;
  always_comb begin
    if (z_q < 0) begin
      tilt_clip = 16'd0;
    end else if (z_q > ZW'(TILT_MAX)) begin
      tilt_clip = TILT_MAX;
    end else begin
      tilt_clip = z_q[15:0];
    end
  end

  // held range state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_range_q <= 16'd0;
      last_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_LOAD && sample_ready_i && range_good_i) begin
      last_range_q <= range_mm_i;
      last_valid_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        ax_q     <= abs_f(accel_x_i);
        ay_q     <= abs_f(accel_y_i);
        az_q     <= abs_f(accel_z_i);
        sum_q    <= '0;
        vert_q   <= 16'd0;
        status_q <= (sample_ready_i && !range_good_i) ? ST_FAULT : ST_OK;
      end
      OP_SQUARE: begin
        sum_q <= sum_q + SW'(sq_prod);
      end
      OP_SQRT1_INIT: begin
        rad_q <= RW'(sum_q);
        res_q <= '0;
        bit_q <= RW'(1) << (2 * AW);
      end
      OP_SQRT_STEP: begin
        if (sq_take) begin
          rad_q <= rad_q - sq_trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        m_q   <= MW'(sq_take ? ((res_q >> 1) + bit_q) : (res_q >> 1));
      end
      OP_CHECK: begin
        if (low_acc) begin
          status_q <= ST_LOW_ACCEL;
        end else if (!last_valid_q) begin
          status_q <= ST_NO_RANGE;
        end
        rem_q <= DW'(az_q >> 1);
        nb_q  <= az_q[0];
        quo_q <= 16'd0;
      end
      OP_DIV_STEP: begin
        rem_q <= dv_take ? (dv_t - DW'(m_q)) : dv_t;
        quo_q <= {quo_q[14:0], dv_take};
        nb_q  <= 1'b0;
      end
      OP_MUL: begin
        vert_q <= (vm_shift > 18'd65535) ? 16'hFFFF : vm_shift[15:0];
        cc_q   <= cc_prod[30:0];
      end
      OP_SQRT2_INIT: begin
        rad_q <= RW'(31'h4000_0000 - cc_q);
        res_q <= '0;
        bit_q <= RW'(1) << 30;
      end
      OP_COR_INIT: begin
        x_q <= XW'({quo_q, 8'd0});
        y_q <= XW'({res_q[15:0], 8'd0});
        z_q <= '0;
      end
      OP_COR_STEP: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atn;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atn;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      held_range_mm_o    <= last_range_q;
      held_range_known_o <= last_valid_q;
      vertical_mm_o      <= (status_q == ST_OK) ? vert_q : 16'd0;
      tilt_angle_o       <= (status_q == ST_OK) ? tilt_clip : 16'd0;
      ok_o               <= (status_q == ST_OK);
      status_o           <= status_q;
    end
  end

  assign sts_o.early = (status_q != ST_OK);

endmodule

@@ hw/rtl/tcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcr_ctrl
// sequencer for the tilt-corrected ranger, owns both handshakes
// ----------------------------------------------------------------------------
module tcr_ctrl import tcr_pkg::*; #(
  parameter int unsigned AW = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tcr_cmd_t cmd_o,
  input  tcr_sts_t sts_i
);

  localparam int unsigned CNW = $clog2(AW + 2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_SQRT1I = 4'd2;
  localparam logic [3:0] S_SQRT1  = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_SQRT2I = 4'd7;
  localparam logic [3:0] S_SQRT2  = 4'd8;
  localparam logic [3:0] S_CORI   = 4'd9;
  localparam logic [3:0] S_COR    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]     state_q, state_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and command
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NOP;
    cmd_o.idx   = cnt_q[3:0];
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        if (sts_i.early) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SQUARE;
          cnt_d    = cnt_q + CNW'(1);
          if (cnt_q == CNW'(2)) begin
            state_d = S_SQRT1I;
          end
        end
      end
      S_SQRT1I: begin
        cmd_o.op = OP_SQRT1_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT1;
      end
      S_SQRT1: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + CNW'(1);
        if (cnt_q == CNW'(AW)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.op = OP_CHECK;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (sts_i.early) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_DIV_STEP;
          cnt_d    = cnt_q + CNW'(1);
          if (cnt_q == CNW'(CORDIC_STEPS - 1)) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_SQRT2I;
      end
      S_SQRT2I: begin
        cmd_o.op = OP_SQRT2_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT2;
      end
      S_SQRT2: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + CNW'(1);
        if (cnt_q == CNW'(15)) begin
          state_d = S_CORI;
        end
      end
      S_CORI: begin
        cmd_o.op = OP_COR_INIT;
        cnt_d    = '0;
        state_d  = S_COR;
      end
      S_COR: begin
        cmd_o.op = OP_COR_STEP;
        cnt_d    = cnt_q + CNW'(1);
        if (cnt_q == CNW'(CORDIC_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_SQ))
    else $error("accepted transaction did not start work");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished result not presented");

  a_sqrt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT1) |-> (cnt_q <= CNW'(AW)))
    else $error("square root step count overrun");
`endif

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives range and acceleration transactions into tilt_corrected_range at
// random pacing, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module testbench;
  import tcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AW = 16;
  localparam logic [2:0] ADDR_MIN_ACCEL = 3'd0;

  typedef struct {
    logic [15:0] held;
    logic        known;
    logic [15:0] vert;
    logic [15:0] tilt;
    logic        ok;
    logic [1:0]  status;
  } range_res_t;

  typedef struct {
    logic               sr;
    logic [15:0]        rng;
    logic               good;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               typed;
    range_res_t         res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic sample_ready_i = 1'b0;
  logic [15:0] range_mm_i = '0;
  logic range_good_i = 1'b0;
  logic signed [AW-1:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] held_range_mm_o, vertical_mm_o, tilt_angle_o;
  logic held_range_known_o, ok_o;
  logic [1:0] status_o;

  // predictor state and configuration
  logic [15:0] held_range_q;
  logic        range_known_q;
  logic [15:0] min_accel_q;

  range_res_t  pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches = 0;
  bit          pacing_off = 1'b0;

  tilt_corrected_range #(.ACCEL_WIDTH(AW)) dut (.*);

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned int_root(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_of(logic signed [15:0] v);
    longint a;
    a = longint'(v);
    return (a < 0) ? longint'(-a) : longint'(a);
  endfunction

  // tilt angle from the cosine by cordic vectoring
  function automatic logic [15:0] tilt_from_cos(longint unsigned c);
    longint x, y, z, xs, ys;
    longint unsigned s;
    s = int_root((64'd1 << 30) - c * c);
    x = longint'(c << 8);
    y = longint'(s << 8);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + tcr_atan(i[3:0]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - tcr_atan(i[3:0]);
      end
    end
    if (z < 0) z = 0;
    if (z > TILT_MAX) z = TILT_MAX;
    return z[15:0];
  endfunction

  // expected result of one transaction, updating the held range
  function automatic range_res_t corrected_range(stim_row_t t);
    range_res_t r;
    longint unsigned ax, ay, az, m, c, v;
    r = '{default: '0};
    r.status = ST_OK;
    if (t.sr) begin
      if (t.good) begin
        held_range_q = t.rng;
        range_known_q = 1'b1;
      end else begin
        r.status = ST_FAULT;
      end
    end
    if (r.status == ST_OK) begin
      ax = mag_of(t.ax);
      ay = mag_of(t.ay);
      az = mag_of(t.az);
      m = int_root(ax * ax + ay * ay + az * az);
      if (m == 0 || m < min_accel_q) begin
        r.status = ST_LOW_ACCEL;
      end else if (!range_known_q) begin
        r.status = ST_NO_RANGE;
      end else begin
        c = (az << 15) / m;
        if (c > 32768) c = 32768;
        v = (longint'(held_range_q) * c + 16384) >> 15;
        if (v > 16'hffff) v = 16'hffff;
        r.vert = v[15:0];
        r.tilt = tilt_from_cos(c);
        r.ok = 1'b1;
      end
    end
    r.held = held_range_q;
    r.known = range_known_q;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_result(range_res_t g, range_res_t w);
    if (g.held !== w.held) report("held_range_mm", g.held, w.held);
    if (g.known !== w.known) report("held_range_known", g.known, w.known);
    if (g.vert !== w.vert) report("vertical_mm", g.vert, w.vert);
    if (g.tilt !== w.tilt) report("tilt_angle", g.tilt, w.tilt);
    if (g.ok !== w.ok) report("ok", g.ok, w.ok);
    if (g.status !== w.status) report("status", g.status, w.status);
  endtask

  // result monitor
  always @(posedge clk_i) begin
    range_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{held_range_mm_o, held_range_known_o, vertical_mm_o, tilt_angle_o,
              ok_o, status_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no transaction waiting", $realtime);
      end else begin
        check_result(got, pending_results.pop_front());
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= !pacing_off && ($urandom_range(99) < 14);
  end

  task automatic write_min_accel(logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_MIN_ACCEL; pwdata <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    min_accel_q = val;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait for every result, then let the block drain
  task automatic drain();
    int unsigned n;
    n = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (n < 120) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic send(stim_row_t t);
    range_res_t w;
    @(negedge clk_i);
    while (!pacing_off && $urandom_range(99) < 14) @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_ready_i <= t.sr; range_mm_i <= t.rng; range_good_i <= t.good;
    accel_x_i <= t.ax; accel_y_i <= t.ay; accel_z_i <= t.az;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    w = corrected_range(t);
    if (t.typed) check_result(w, t.res);
    pending_results.push_back(w);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic add_row(logic sr, logic [15:0] rng, logic good, logic [15:0] ax,
                         logic [15:0] ay, logic [15:0] az, logic typed,
                         logic [1:0] st, logic ok, logic known, logic [15:0] held);
    stim_row_t t;
    t = '{sr, rng, good, ax, ay, az, typed, '{held, known, 16'd0, 16'd0, ok, st}};
    directed_rows.push_back(t);
  endtask

  function automatic logic [15:0] rand_accel(int unsigned kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 1400)) - 16'd700;
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom_range(0, 8000)) - 16'd4000;
    endcase
  endfunction

  task automatic random_items(int unsigned count);
    stim_row_t t;
    int unsigned kind;
    for (int unsigned i = 0; i < count; i++) begin
      pacing_off = (i >= count / 3) && (i < count / 3 + 80);
      kind = $urandom_range(3);
      t.sr = ($urandom_range(99) < 80);
      t.good = ($urandom_range(99) < 85);
      t.rng = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom());
      t.ax = rand_accel(kind);
      t.ay = rand_accel(kind);
      t.az = ($urandom_range(3) == 0) ? rand_accel(2) : rand_accel(kind);
      if ($urandom_range(49) == 0) begin
        t.ax = '0; t.ay = '0; t.az = '0;
      end
      t.typed = 1'b0;
      send(t);
    end
    pacing_off = 1'b0;
  endtask

  // stimulus
  initial begin
    held_range_q = '0;
    range_known_q = 1'b0;
    min_accel_q = 16'd512;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, faults, extremes, thresholds
    add_row(0, 0, 0, 0, 0, 0, 1, ST_LOW_ACCEL, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 1000, 1, ST_NO_RANGE, 0, 0, 0);
    add_row(1, 1234, 0, 0, 0, 1000, 1, ST_FAULT, 0, 0, 0);
    add_row(1, 1000, 1, 0, 0, 1000, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 16'h8000, 16'h8000, 16'h8000, 1, ST_FAULT, 0, 1, 1000);
    add_row(0, 5555, 1, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0);
    add_row(1, 65535, 1, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
    add_row(1, 0, 1, 1000, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 65535, 1, 16'h8000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 100, 100, 100, 1, ST_LOW_ACCEL, 0, 1, 65535);
    add_row(1, 65535, 1, 511, 0, 0, 1, ST_LOW_ACCEL, 0, 1, 65535);
    add_row(1, 65535, 1, 512, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 40000, 1, 3000, 16'hf060, 5000, 0, 0, 0, 0, 0);
    add_row(1, 1, 1, 0, 0, 16'hfda8, 0, 0, 0, 0, 0);
    add_row(1, 65535, 1, 16'hffff, 16'hffff, 16'h8000, 0, 0, 0, 0, 0);
    add_row(1, 65535, 0, 16'h5555, 16'haaaa, 16'h5555, 1, ST_FAULT, 0, 1, 65535);
    foreach (directed_rows[i]) send(directed_rows[i]);
    random_items(450);

    // threshold off: zero acceleration still low
    drain();
    write_min_accel(16'd0);
    add_row(0, 0, 0, 0, 0, 0, 1, ST_LOW_ACCEL, 0, 1, held_range_q);
    send(directed_rows[directed_rows.size() - 1]);
    random_items(450);

    // threshold at its top: every magnitude too small
    drain();
    write_min_accel(16'hffff);
    random_items(150);

    drain();
    write_min_accel(16'($urandom_range(300, 9000)));
    random_items(400);

    drain();
    write_min_accel(16'd512);
    random_items(380);

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ tilt_corrected_range.f @@
hw/rtl/tcr_pkg.sv
hw/rtl/tcr_datapath.sv
hw/rtl/tcr_ctrl.sv
hw/rtl/tilt_corrected_range.sv
dv/testbench.sv
